[hw/rtl/pd3_pkg.sv]
// Shared constants, types and codes for the 3x3 polar decomposition unit.
// Depends on nothing; every other file refers to it by scoped names.
package pd3_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 24;
  localparam int unsigned ITER_W         = 12;
  localparam logic [ITER_W-1:0] ITER_RESET = 12'd1000;

  // Datapath commands issued by the controller
  localparam int unsigned CMD_W = 3;
  localparam logic [CMD_W-1:0] CMD_NOP   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd1; // latch input matrix
  localparam logic [CMD_W-1:0] CMD_COF   = 3'd2; // one product of a cofactor
  localparam logic [CMD_W-1:0] CMD_DET   = 3'd3; // one determinant term
  localparam logic [CMD_W-1:0] CMD_DSTRT = 3'd4; // start a division
  localparam logic [CMD_W-1:0] CMD_DSTEP = 3'd5; // one quotient bit
  localparam logic [CMD_W-1:0] CMD_DFIN  = 3'd6; // average into Q
  localparam logic [CMD_W-1:0] CMD_OUT   = 3'd7; // move Q to output register

  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic [3:0]       idx;   // element index 0..8
    logic             half;  // second product of a cofactor, or high part of a determinant term
  } pd3_cmd_t;

  typedef struct packed {
    logic det_zero;
    logic div_done;
  } pd3_sts_t;

endpackage

[hw/rtl/pd3_if.sv]
// Valid/ready channel interfaces for the polar decomposition unit.
// Depends on pd3_pkg for default widths.
interface pd3_in_if #(
  parameter int unsigned DATA_WIDTH = pd3_pkg::DATA_WIDTH_DEF
);
  logic valid;
  logic ready;
  logic signed [DATA_WIDTH-1:0] in_m00, in_m01, in_m02, in_m10, in_m11, in_m12,
                                in_m20, in_m21, in_m22;
  modport source (output valid, in_m00, in_m01, in_m02, in_m10, in_m11, in_m12,
                  in_m20, in_m21, in_m22, input ready);
  modport sink (input valid, in_m00, in_m01, in_m02, in_m10, in_m11, in_m12,
                in_m20, in_m21, in_m22, output ready);
endinterface

interface pd3_out_if #(
  parameter int unsigned DATA_WIDTH = pd3_pkg::DATA_WIDTH_DEF
);
  logic valid;
  logic ready;
  logic signed [DATA_WIDTH-1:0] rot_m00, rot_m01, rot_m02, rot_m10, rot_m11, rot_m12,
                                rot_m20, rot_m21, rot_m22;
  logic singular;
  modport source (output valid, rot_m00, rot_m01, rot_m02, rot_m10, rot_m11, rot_m12,
                  rot_m20, rot_m21, rot_m22, singular, input ready);
  modport sink (input valid, rot_m00, rot_m01, rot_m02, rot_m10, rot_m11, rot_m12,
                rot_m20, rot_m21, rot_m22, singular, output ready);
endinterface

[hw/rtl/polar_decomposition_3x3_unit.sv]
// Polar decomposition 3x3 unit: top level with config register and output register.
// Depends on pd3_pkg, pd3_if, pd3_ctrl, pd3_datapath.

// One matrix is processed at a time. Each Newton step computes the cofactors and
// the determinant on the shared multiplier, makes one check and runs nine divisions
// on one shared restoring divider; an item runs iteration_count steps, fewer
// when a zero determinant ends it early. The result sits in an output register, so
// the next matrix is accepted while it waits.
module polar_decomposition_3x3_unit #(
  parameter int unsigned DATA_WIDTH = pd3_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = pd3_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [pd3_pkg::ITER_W-1:0]  cfg_wdata,
  pd3_in_if.sink                      in_ch,
  pd3_out_if.source                   out_ch
);
  localparam int unsigned DW = DATA_WIDTH;

  logic [pd3_pkg::ITER_W-1:0] iter_r;
  logic out_valid_r;
  logic [9*DW-1:0] in_flat, q_flat;
  logic [DW-1:0] rot_r [9];
  logic sing_out_r;
  pd3_pkg::pd3_cmd_t cmd;
  pd3_pkg::pd3_sts_t sts;
  logic idle, done, sing, in_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) iter_r <= pd3_pkg::ITER_RESET;
    else if (cfg_we) iter_r <= cfg_wdata;
  end

  assign in_ch.ready = idle;
  assign in_fire = in_ch.valid & idle;
  assign in_flat = {in_ch.in_m22, in_ch.in_m21, in_ch.in_m20, in_ch.in_m12, in_ch.in_m11,
                    in_ch.in_m10, in_ch.in_m02, in_ch.in_m01, in_ch.in_m00};

  pd3_ctrl #(.DATA_WIDTH(DW)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .iter_cnt(iter_r), .in_fire(in_fire),
    .out_busy(out_valid_r & ~out_ch.ready), .sts(sts), .cmd(cmd),
    .idle(idle), .done(done), .sing(sing)
  );

  pd3_datapath #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .cmd(cmd), .in_flat(in_flat), .q_flat(q_flat), .sts(sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (done) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (done) begin
      for (int k = 0; k < 9; k++) rot_r[k] <= sing ? '0 : q_flat[k*DW +: DW];
      sing_out_r <= sing;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.rot_m00 = rot_r[0];
  assign out_ch.rot_m01 = rot_r[1];
  assign out_ch.rot_m02 = rot_r[2];
  assign out_ch.rot_m10 = rot_r[3];
  assign out_ch.rot_m11 = rot_r[4];
  assign out_ch.rot_m12 = rot_r[5];
  assign out_ch.rot_m20 = rot_r[6];
  assign out_ch.rot_m21 = rot_r[7];
  assign out_ch.rot_m22 = rot_r[8];
  assign out_ch.singular = sing_out_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !idle) else $error("accepted matrix did not start work");
  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> out_valid_r) else $error("finished result not presented");
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && sing_out_r) |-> (rot_r[0] == '0 && rot_r[4] == '0))
    else $error("singular result not zero");
endmodule

[hw/rtl/pd3_datapath.sv]
// Datapath: matrix register, cofactor/determinant multiplier, restoring divider.
// Depends on pd3_pkg; driven by pd3_ctrl commands.
module pd3_datapath #(
  parameter int unsigned DATA_WIDTH = pd3_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = pd3_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  pd3_pkg::pd3_cmd_t            cmd,
  input  logic [9*DATA_WIDTH-1:0]      in_flat,
  output logic [9*DATA_WIDTH-1:0]      q_flat,
  output pd3_pkg::pd3_sts_t            sts
);
  localparam int unsigned DW  = DATA_WIDTH;
  localparam int unsigned CW  = 2*DW + 1;           // cofactor
  localparam int unsigned DTW = 3*DW + 3;           // determinant
  localparam int unsigned NW  = CW + 2*FRAC_BITS;   // shifted numerator
  localparam int unsigned SW  = DTW + DW;           // shifted divisor
  localparam int unsigned CMPW = (SW > NW) ? SW : NW;
  localparam int unsigned QCW = $clog2(DW+1);

  logic signed [DW-1:0]  q_r [9];
  logic signed [CW-1:0]  cof_r [9];
  logic signed [DTW-1:0] det_r;
  logic signed [CW-1:0]  p1_r;
  logic [NW-1:0]   num_r;
  logic [SW-1:0]   ds_r;
  logic [DW-1:0]   quo_r;
  logic            neg_r, sat_r;
  logic [QCW-1:0]  bit_r;

  // operand selection for the shared multiplier
  logic [1:0] ra, rb, ca, cb, r, c;
  logic signed [DW-1:0] ma, mb;
  logic signed [DW:0]   mbx;
  logic signed [CW-1:0] prod;

  function automatic logic [1:0] inc3(input logic [1:0] v);
    inc3 = (v == 2'd2) ? 2'd0 : v + 2'd1;
  endfunction

  always_comb begin
    if (cmd.idx < 4'd3) begin
      r = 2'd0;
      c = cmd.idx[1:0];
    end else if (cmd.idx < 4'd6) begin
      r = 2'd1;
      c = 2'(cmd.idx - 4'd3);
    end else begin
      r = 2'd2;
      c = 2'(cmd.idx - 4'd6);
    end
    ra = inc3(r);  rb = inc3(ra);
    ca = inc3(c);  cb = inc3(ca);
    ma = q_r[0];
    mb = q_r[0];
    if (cmd.op == pd3_pkg::CMD_DET) begin
      ma = q_r[cmd.idx];
    end else if (!cmd.half) begin
      ma = q_r[4'(ra)*4'd3 + 4'(ca)];
      mb = q_r[4'(rb)*4'd3 + 4'(cb)];
    end else begin
      ma = q_r[4'(ra)*4'd3 + 4'(cb)];
      mb = q_r[4'(rb)*4'd3 + 4'(ca)];
    end
    // determinant term: Q times the low (unsigned) or high (signed) part of the cofactor
    if (cmd.op == pd3_pkg::CMD_DET)
      mbx = cmd.half ? $signed(cof_r[cmd.idx][CW-1:DW])
                     : $signed({1'b0, cof_r[cmd.idx][DW-1:0]});
    else
      mbx = {mb[DW-1], mb};
    prod = CW'(ma) * CW'(mbx);
  end

  logic [NW-1:0] ncand;
  logic [SW-1:0] dcand, ds_half;
  logic [CW-1:0] cabs;
  logic [DTW-1:0] dabs;
  logic ge;
  logic signed [DW-1:0] tval, maxv, minv;
  logic signed [DW:0] hs;

  always_comb begin
    cabs = cof_r[cmd.idx][CW-1] ? CW'(-cof_r[cmd.idx]) : CW'(cof_r[cmd.idx]);
    dabs = det_r[DTW-1] ? DTW'(-det_r) : DTW'(det_r);
    ncand = NW'(cabs) << (2*FRAC_BITS);
    dcand = SW'(dabs) << (DW-1);
    ds_half = ds_r >> 1;
    ge = (CMPW'(ds_half) <= CMPW'(num_r));
    maxv = {1'b0, {(DW-1){1'b1}}};
    minv = {1'b1, {(DW-1){1'b0}}};
    if (sat_r) tval = neg_r ? minv : maxv;
    else tval = neg_r ? -$signed(quo_r) : $signed(quo_r);
    hs = ($signed({q_r[cmd.idx][DW-1], q_r[cmd.idx]}) + $signed({tval[DW-1], tval})) >>> 1;
  end

  // wide compare for saturation check
  logic sat_c;
  always_comb begin
    sat_c = (CMPW'(dcand) <= CMPW'(ncand));
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      pd3_pkg::CMD_LOAD: begin
        for (int k = 0; k < 9; k++) q_r[k] <= in_flat[k*DW +: DW];
        det_r <= '0;
      end
      pd3_pkg::CMD_COF: begin
        if (!cmd.half) p1_r <= prod;
        else cof_r[cmd.idx] <= p1_r - prod;
        det_r <= '0;
      end
      pd3_pkg::CMD_DET: det_r <= det_r + (cmd.half ? (DTW'(prod) <<< DW) : DTW'(prod));
      pd3_pkg::CMD_DSTRT: begin
        num_r <= ncand;
        ds_r  <= dcand;
        sat_r <= sat_c;
        neg_r <= cof_r[cmd.idx][CW-1] ^ det_r[DTW-1];
        quo_r <= '0;
        bit_r <= QCW'(DW-1);
      end
      pd3_pkg::CMD_DSTEP: begin
        ds_r <= ds_half;
        if (ge) num_r <= num_r - NW'(ds_half);
        quo_r <= {quo_r[DW-2:0], ge};
        bit_r <= bit_r - 1'b1;
      end
      pd3_pkg::CMD_DFIN: q_r[cmd.idx] <= hs[DW-1:0];
      default: ;
    endcase
  end

  always_comb begin
    for (int k = 0; k < 9; k++) q_flat[k*DW +: DW] = q_r[k];
    sts.det_zero = (det_r == '0);
    sts.div_done = (bit_r == QCW'(1));
  end
endmodule

[hw/rtl/pd3_ctrl.sv]
// Controller FSM sequencing cofactors, determinant, nine divisions per step.
// Depends on pd3_pkg.
module pd3_ctrl #(
  parameter int unsigned DATA_WIDTH = pd3_pkg::DATA_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [pd3_pkg::ITER_W-1:0] iter_cnt,
  input  logic                      in_fire,
  input  logic                      out_busy,
  input  pd3_pkg::pd3_sts_t         sts,
  output pd3_pkg::pd3_cmd_t         cmd,
  output logic                      idle,
  output logic                      done,
  output logic                      sing
);
  localparam logic [2:0] S_IDLE = 3'd0, S_COF = 3'd1, S_DET = 3'd2, S_CHK = 3'd3,
                         S_DST = 3'd4, S_DIV = 3'd5, S_FIN = 3'd6, S_OUT = 3'd7;

  logic [2:0] st_r, st_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic       half_r, half_nxt;
  logic [pd3_pkg::ITER_W-1:0] it_r, it_nxt;
  logic       sing_r, sing_nxt;

  always_comb begin
    st_nxt = st_r; idx_nxt = idx_r; half_nxt = half_r; it_nxt = it_r; sing_nxt = sing_r;
    cmd.op = pd3_pkg::CMD_NOP; cmd.idx = idx_r; cmd.half = half_r;
    done = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.op = pd3_pkg::CMD_LOAD;
          it_nxt = iter_cnt; sing_nxt = 1'b0; idx_nxt = '0; half_nxt = 1'b0;
          st_nxt = (iter_cnt == '0) ? S_OUT : S_COF;
        end
      end
      S_COF: begin
        cmd.op = pd3_pkg::CMD_COF;
        half_nxt = ~half_r;
        if (half_r) begin
          idx_nxt = (idx_r == 4'd8) ? 4'd0 : idx_r + 4'd1;
          if (idx_r == 4'd8) st_nxt = S_DET;
        end
      end
      S_DET: begin
        // two partial products per determinant term
        cmd.op = pd3_pkg::CMD_DET;
        half_nxt = ~half_r;
        if (half_r) begin
          idx_nxt = (idx_r == 4'd2) ? 4'd0 : idx_r + 4'd1;
          if (idx_r == 4'd2) st_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.det_zero) begin
          sing_nxt = 1'b1; st_nxt = S_OUT;
        end else st_nxt = S_DST;
      end
      S_DST: begin
        cmd.op = pd3_pkg::CMD_DSTRT; st_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = pd3_pkg::CMD_DSTEP;
        if (sts.div_done) st_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.op = pd3_pkg::CMD_DFIN;
        if (idx_r == 4'd8) begin
          idx_nxt = '0;
          it_nxt = it_r - 1'b1;
          st_nxt = (it_r == pd3_pkg::ITER_W'(1)) ? S_OUT : S_COF;
        end else begin
          idx_nxt = idx_r + 4'd1; st_nxt = S_DST;
        end
      end
      S_OUT: begin
        if (!out_busy) begin
          cmd.op = pd3_pkg::CMD_OUT; done = 1'b1; st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; idx_r <= '0; half_r <= 1'b0; it_r <= '0; sing_r <= 1'b0;
    end else begin
      st_r <= st_nxt; idx_r <= idx_nxt; half_r <= half_nxt; it_r <= it_nxt;
      sing_r <= sing_nxt;
    end
  end

  assign idle = (st_r == S_IDLE);
  assign sing = sing_r;
endmodule
